@@ rtl/core/ffsa_pkg.sv @@
// ffsa_pkg: shared constants, command codes and the token control struct
// for the first-free slot allocator. No dependencies.
`default_nettype none

package ffsa_pkg;

   // Default number of slot cells
   localparam int SLOTS_DEFAULT = 256;

   // Field widths
   localparam int CMD_W   = 2;
   localparam int OWNER_W = 31;
   localparam int SLOT_W  = 8;
   localparam int SIZE_W  = 9;

   // Register map
   localparam int CSR_ADDR_W     = 2;
   localparam int CSR_DATA_W     = 32;
   localparam int REG_ROOM_SIZE  = 0;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_RESERVE = 2'd0;
   localparam cmd_type CMD_RELEASE = 2'd1;
   localparam cmd_type CMD_QUERY   = 2'd2;

   // Control part of a request token moving down the cell chain
   typedef struct packed {
      logic    valid;  // slot holds a request
      cmd_type cmd;
      logic    pend;   // request still looks for its cell
      logic    hit;    // request has succeeded
   } tok_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/core/ffsa_cell.sv @@
// ffsa_cell: one slot of the allocator chain. Holds the busy bit and owner
// tag of slot IDX and passes the request token on. Uses ffsa_pkg.
`default_nettype none

module ffsa_cell #(
   parameter int SLOTS = 256,
   parameter int IDX   = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          clear,
   input  wire logic [$clog2(SLOTS+1)-1:0]    eff_size,
   input  wire ffsa_pkg::tok_ctrl_type        ctl_i,
   input  wire logic [ffsa_pkg::OWNER_W-1:0]  owner_i,
   input  wire logic [$clog2(SLOTS)-1:0]      slot_i,
   output      ffsa_pkg::tok_ctrl_type        ctl_o,
   output      logic [ffsa_pkg::OWNER_W-1:0]  owner_o,
   output      logic [$clog2(SLOTS)-1:0]      slot_o
);
   import ffsa_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int EW = $clog2(SLOTS+1);

   logic                busy_ff, busy_in;
   logic [OWNER_W-1:0]  own_ff, own_in;
   tok_ctrl_type        ctl_ff, ctl_in;
   logic [OWNER_W-1:0]  tok_owner_ff, tok_owner_in;
   logic [IW-1:0]       tok_slot_ff, tok_slot_in;
   logic                live;
   logic                match;

   assign live  = EW'(IDX) < eff_size;
   assign match = slot_i == IW'(IDX);

   // Act on a pending token that reaches this slot
   always_comb begin
      busy_in      = busy_ff;
      own_in       = own_ff;
      ctl_in       = ctl_i;
      tok_owner_in = owner_i;
      tok_slot_in  = slot_i;
      if (ctl_i.valid && ctl_i.pend) begin
         case (ctl_i.cmd)
            CMD_RESERVE: begin
               if (!busy_ff && live) begin
                  busy_in     = 1'b1;
                  own_in      = owner_i;
                  ctl_in.pend = 1'b0;
                  ctl_in.hit  = 1'b1;
                  tok_slot_in = IW'(IDX);
               end
            end
            CMD_RELEASE: begin
               if (match) begin
                  ctl_in.pend = 1'b0;
                  if (busy_ff) begin
                     ctl_in.hit   = 1'b1;
                     tok_owner_in = own_ff;
                     busy_in      = 1'b0;
                  end
               end
            end
            CMD_QUERY: begin
               if (match) begin
                  ctl_in.pend = 1'b0;
                  ctl_in.hit  = 1'b1;
                  if (busy_ff) begin
                     tok_owner_in = own_ff;
                  end
               end
            end
            default: begin
               ctl_in.pend = 1'b0;
            end
         endcase
      end
   end

   // Slot state: clear on reset or a size write, else advance with the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (clear) begin
         busy_ff <= 1'b0;
      end else if (adv) begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         own_ff       <= own_in;
         tok_owner_ff <= tok_owner_in;
         tok_slot_ff  <= tok_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   assign ctl_o   = ctl_ff;
   assign owner_o = tok_owner_ff;
   assign slot_o  = tok_slot_ff;

endmodule

`default_nettype wire

@@ rtl/core/ffsa_tail.sv @@
// ffsa_tail: end of the cell chain. Keeps the taken-slot count and holds
// the result register toward the output channel. Uses ffsa_pkg.
`default_nettype none

module ffsa_tail #(
   parameter int SLOTS = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          clear,
   input  wire logic [$clog2(SLOTS+1)-1:0]    eff_size,
   input  wire ffsa_pkg::tok_ctrl_type        ctl_i,
   input  wire logic [ffsa_pkg::OWNER_W-1:0]  owner_i,
   input  wire logic [$clog2(SLOTS)-1:0]      slot_i,
   input  wire logic                          out_ready,
   output      logic                          adv,
   output      logic                          out_valid,
   output      logic                          out_failed,
   output      logic [ffsa_pkg::SLOT_W-1:0]   out_granted,
   output      logic [ffsa_pkg::OWNER_W-1:0]  out_owner,
   output      logic [ffsa_pkg::SIZE_W-1:0]   out_free,
   output      logic [ffsa_pkg::SIZE_W-1:0]   out_taken
);
   import ffsa_pkg::*;

   localparam int EW = $clog2(SLOTS+1);

   logic                valid_ff;
   logic [EW-1:0]       taken_ff, taken_in;
   logic                failed_ff;
   logic [SLOT_W-1:0]   granted_ff, granted_in;
   logic [OWNER_W-1:0]  owner_ff, owner_in;
   logic [SIZE_W-1:0]   free_ff, taken_out_ff;
   logic                is_res;

   // Chain moves whenever the result register is empty or being drained
   assign adv    = !valid_ff || out_ready;
   assign is_res = ctl_i.cmd == CMD_RESERVE;

   // Count after this request, and result fields
   always_comb begin
      taken_in = taken_ff;
      if (ctl_i.valid && ctl_i.hit && is_res) begin
         taken_in = taken_ff + EW'(1);
      end else if (ctl_i.valid && ctl_i.hit && ctl_i.cmd == CMD_RELEASE) begin
         taken_in = taken_ff - EW'(1);
      end
      granted_in = (is_res && ctl_i.hit) ? SLOT_W'(slot_i) : '0;
      owner_in   = is_res ? '0 : owner_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (clear) begin
            taken_ff <= '0;
         end else if (adv) begin
            taken_ff <= taken_in;
         end
         if (adv) begin
            valid_ff <= ctl_i.valid;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (adv) begin
         failed_ff    <= !ctl_i.hit;
         granted_ff   <= granted_in;
         owner_ff     <= owner_in;
         free_ff      <= SIZE_W'(eff_size - taken_in);
         taken_out_ff <= SIZE_W'(taken_in);
      end
   end

   assign out_valid   = valid_ff;
   assign out_failed  = failed_ff;
   assign out_granted = granted_ff;
   assign out_owner   = owner_ff;
   assign out_free    = free_ff;
   assign out_taken   = taken_out_ff;

endmodule

`default_nettype wire

@@ rtl/core/first_free_slot_allocator.sv @@
// A request passes through the register of every slot cell in turn, then the
// result register. Throughput: one request per cycle; the whole chain holds
// while a result waits on rsp_tready.
// Reset: room size 0, every slot free, taken count 0. A write to room_size
// frees every slot and zeroes the count in the same cycle.
// Top level of the allocator; uses ffsa_pkg, ffsa_cell and ffsa_tail.
`default_nettype none

module first_free_slot_allocator #(
   parameter int SLOTS = ffsa_pkg::SLOTS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request channel
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [39:0]                      req_tdata,  // owner_in[30:0], slot_in[38:31]
   input  wire logic [1:0]                       req_tuser,  // cmd[1:0]
   // Result channel
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [63:0]                      rsp_tdata,  // slot_granted[7:0],
                                                             // owner_out[38:8],
                                                             // free_slots[47:39],
                                                             // taken_slots[56:48]
   output      logic [0:0]                       rsp_tuser,  // failed[0]
   // Configuration port
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [ffsa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [ffsa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output      logic [ffsa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output      logic                             csr_pready
);
   import ffsa_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int EW = $clog2(SLOTS+1);

   logic [SIZE_W-1:0]   room_ff;
   logic [EW-1:0]       eff_size;
   logic                wr_room;
   logic                adv;

   cmd_type             in_cmd;
   logic [OWNER_W-1:0]  in_owner;
   logic [SLOT_W-1:0]   in_slot;
   logic                in_range;
   logic                in_pend;

   tok_ctrl_type        ctl_chain   [0:SLOTS];
   logic [OWNER_W-1:0]  owner_chain [0:SLOTS];
   logic [IW-1:0]       slot_chain  [0:SLOTS];

   logic                out_failed;
   logic [SLOT_W-1:0]   out_granted;
   logic [OWNER_W-1:0]  out_owner;
   logic [SIZE_W-1:0]   out_free;
   logic [SIZE_W-1:0]   out_taken;

   // Register access: one word, byte lanes ignored
   assign csr_pready = 1'b1;
   assign wr_room    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr >> 2) == CSR_ADDR_W'(REG_ROOM_SIZE);
   assign csr_prdata = CSR_DATA_W'(room_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         room_ff <= '0;
      end else if (wr_room) begin
         room_ff <= csr_pwdata[SIZE_W-1:0];
      end
   end

   // Clamp the room to the cell count
   assign eff_size = (32'(room_ff) > 32'(SLOTS)) ? EW'(SLOTS) : EW'(room_ff);

   // Decode the incoming transfer into a token
   assign in_cmd   = req_tuser;
   assign in_owner = req_tdata[OWNER_W-1:0];
   assign in_slot  = req_tdata[OWNER_W +: SLOT_W];
   assign in_range = 32'(in_slot) < 32'(eff_size);

   assign req_tready = adv;

   always_comb begin
      case (in_cmd)
         CMD_RESERVE: in_pend = in_owner != '0 && eff_size != '0;
         CMD_RELEASE: in_pend = in_range;
         CMD_QUERY:   in_pend = in_range;
         default:     in_pend = 1'b0;
      endcase
   end

   assign ctl_chain[0]   = '{valid: req_tvalid, cmd: in_cmd, pend: in_pend, hit: 1'b0};
   assign owner_chain[0] = (in_cmd == CMD_RESERVE) ? in_owner : '0;
   assign slot_chain[0]  = IW'(in_slot);

   // Row of slot cells
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      ffsa_cell #(
         .SLOTS (SLOTS),
         .IDX   (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .clear    (wr_room),
         .eff_size (eff_size),
         .ctl_i    (ctl_chain[g]),
         .owner_i  (owner_chain[g]),
         .slot_i   (slot_chain[g]),
         .ctl_o    (ctl_chain[g+1]),
         .owner_o  (owner_chain[g+1]),
         .slot_o   (slot_chain[g+1])
      );
   end

   // Count and result register
   ffsa_tail #(
      .SLOTS (SLOTS)
   ) u_tail (
      .clock       (clock),
      .reset       (reset),
      .clear       (wr_room),
      .eff_size    (eff_size),
      .ctl_i       (ctl_chain[SLOTS]),
      .owner_i     (owner_chain[SLOTS]),
      .slot_i      (slot_chain[SLOTS]),
      .out_ready   (rsp_tready),
      .adv         (adv),
      .out_valid   (rsp_tvalid),
      .out_failed  (out_failed),
      .out_granted (out_granted),
      .out_owner   (out_owner),
      .out_free    (out_free),
      .out_taken   (out_taken)
   );

   assign rsp_tdata = {7'd0, out_taken, out_free, out_owner, out_granted};
   assign rsp_tuser = out_failed;

endmodule

`default_nettype wire

@@ tb/tb_first_free_slot_allocator.sv @@
// Self-checking testbench for first_free_slot_allocator: request and result streams
// plus room_size writes over the APB-style port, checked against an in-bench allocator.
// Depends on ffsa_pkg and the allocator RTL only.
module tb_first_free_slot_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   import ffsa_pkg::*;

   localparam int      TABLE_DEPTH  = SLOTS_DEFAULT;
   localparam int      CHAIN_CYCLES = SLOTS_DEFAULT + 1;
   localparam int      CYCLE_LIMIT  = 400000;
   localparam int      HOLD_CYCLES  = 500;
   localparam int      IDLE_PCT     = 9;
   localparam cmd_type CMD_UNUSED   = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ROOM_SIZE_ADDR = CSR_ADDR_W'(4 * REG_ROOM_SIZE);

   // Predicts allocator results and holds the ones still to arrive
   class slot_scoreboard;
      typedef struct packed {
         logic                failed;
         logic [SLOT_W-1:0]   slot;
         logic [OWNER_W-1:0]  owner;
         logic [SIZE_W-1:0]   free_cnt;
         logic [SIZE_W-1:0]   taken_cnt;
      } grant_result_type;

      bit [OWNER_W-1:0] owner_of [TABLE_DEPTH];
      bit               taken [TABLE_DEPTH];
      bit [SIZE_W-1:0]  taken_count;
      bit [SIZE_W-1:0]  room_size;
      grant_result_type expected_q [$];
      int               mismatches;

      function new();
         mismatches = 0;
         set_room('0);
      endfunction

      // A room_size write frees every slot
      function void set_room(bit [SIZE_W-1:0] size);
         room_size = size;
         foreach (owner_of[i]) begin
            owner_of[i] = '0;
            taken[i]    = 1'b0;
         end
         taken_count = '0;
      endfunction

      // Sizes above the table depth act as the full table
      function int unsigned usable();
         return (room_size > TABLE_DEPTH) ? TABLE_DEPTH : room_size;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Random taken slot, or -1 when the room is empty
      function int any_taken_slot();
         int start;
         start = $urandom_range(0, TABLE_DEPTH - 1);
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (taken[(start + k) % TABLE_DEPTH]) return (start + k) % TABLE_DEPTH;
         end
         return -1;
      endfunction

      // Apply one accepted request to the table and queue its result
      function void note_request(cmd_type cmd, bit [OWNER_W-1:0] owner, bit [SLOT_W-1:0] slot);
         grant_result_type r;
         int unsigned      size;
         size     = usable();
         r        = '0;
         r.failed = 1'b1;
         case (cmd)
            CMD_RESERVE: begin
               if (owner != '0 && taken_count < size) begin
                  for (int i = 0; i < size; i++) begin
                     if (!taken[i]) begin
                        taken[i]    = 1'b1;
                        owner_of[i] = owner;
                        taken_count = taken_count + 1'b1;
                        r.slot      = SLOT_W'(i);
                        r.failed    = 1'b0;
                        break;
                     end
                  end
               end
            end
            CMD_RELEASE: begin
               if (slot < size && taken[slot]) begin
                  r.owner        = owner_of[slot];
                  owner_of[slot] = '0;
                  taken[slot]    = 1'b0;
                  if (taken_count != '0) taken_count = taken_count - 1'b1;
                  r.failed       = 1'b0;
               end
            end
            CMD_QUERY: begin
               if (slot < size) begin
                  r.owner  = taken[slot] ? owner_of[slot] : '0;
                  r.failed = 1'b0;
               end
            end
            default: ;
         endcase
         r.free_cnt  = SIZE_W'(size) - taken_count;
         r.taken_cnt = taken_count;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      // Compare one accepted result with the oldest prediction
      function void check_result(logic [63:0] data, logic fail_bit);
         grant_result_type e;
         if (expected_q.size() == 0) begin
            $error("result transfer with no request outstanding: data %h", data);
            mismatches++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("failed", e.failed, fail_bit);
         compare_field("slot_granted", e.slot, data[7:0]);
         compare_field("owner_out", e.owner, data[38:8]);
         compare_field("free_slots", e.free_cnt, data[47:39]);
         compare_field("taken_slots", e.taken_cnt, data[56:48]);
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [39:0]           req_tdata   = '0;  // owner_in[30:0], slot_in[38:31]
   logic [1:0]            req_tuser   = '0;  // cmd[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [63:0]           rsp_tdata;         // slot_granted[7:0], owner_out[38:8],
                                             // free_slots[47:39], taken_slots[56:48]
   logic [0:0]            rsp_tuser;         // failed[0]
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic                  steady          = 1'b0;  // no idling on either side
   logic                  pressure_armed  = 1'b0;
   bit                    pressure_done   = 1'b0;
   int                    hold_left       = 0;
   int                    cycle_count     = 0;

   slot_scoreboard sb = new();

   first_free_slot_allocator uut (.*);

   // Clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[first_free_slot_allocator] ERROR");
         $finish;
      end
   end

   // Result side: check each transfer, then pick the next ready value
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser[0]);
      if (pressure_armed && !pressure_done) begin
         hold_left     = HOLD_CYCLES;
         pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Offer one request and hold it until the transfer
   task automatic send_request(cmd_type cmd, bit [OWNER_W-1:0] owner, bit [SLOT_W-1:0] slot);
      if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, slot, owner};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, owner, slot);
   endtask

   // Drain, write room_size, then read it back
   task automatic write_room(bit [SIZE_W-1:0] size);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ROOM_SIZE_ADDR;
      csr_pwdata  <= CSR_DATA_W'(size);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_room(size);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.compare_field("room_size", CSR_DATA_W'(size), csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Mostly well-formed traffic; the first fill_count items lean hard on reserves
   task automatic run_random(int count, int fill_count);
      int               r, pick, size;
      int               res_cut, rel_cut, qry_cut;
      cmd_type          cmd;
      bit [OWNER_W-1:0] owner;
      bit [SLOT_W-1:0]  slot;
      for (int i = 0; i < count; i++) begin
         size  = sb.usable();
         owner = $urandom();
         if ($urandom_range(0, 99) < 3) owner = '0;
         slot  = $urandom();
         if (i < fill_count) begin
            res_cut = 94; rel_cut = 97; qry_cut = 99;
         end else begin
            res_cut = 40; rel_cut = 70; qry_cut = 95;
         end
         r = $urandom_range(0, 99);
         if (r < res_cut) begin
            cmd = CMD_RESERVE;
         end else if (r < rel_cut) begin
            cmd  = CMD_RELEASE;
            pick = sb.any_taken_slot();
            if (pick >= 0 && $urandom_range(0, 99) < 85) slot = SLOT_W'(pick);
            else if (size > 0 && $urandom_range(0, 99) < 60)
               slot = SLOT_W'($urandom_range(0, size - 1));
         end else if (r < qry_cut) begin
            cmd = CMD_QUERY;
            if (size > 0 && $urandom_range(0, 99) < 75)
               slot = SLOT_W'($urandom_range(0, size - 1));
         end else begin
            cmd = CMD_UNUSED;
         end
         send_request(cmd, owner, slot);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // No room after reset: everything is refused
      send_request(CMD_RESERVE, 31'd5, 8'd0);
      send_request(CMD_RELEASE, 31'd0, 8'd0);
      send_request(CMD_QUERY, 31'd0, 8'd0);

      // Three-slot room: zero owner, fill, full, range, release and reuse
      write_room(9'd3);
      send_request(CMD_RESERVE, 31'd0, 8'd0);
      send_request(CMD_RESERVE, 31'h7FFF_FFFF, 8'hFF);
      send_request(CMD_RESERVE, 31'd1, 8'd0);
      send_request(CMD_RESERVE, 31'h2AAA_AAAA, 8'd0);
      send_request(CMD_RESERVE, 31'd6, 8'd0);
      send_request(CMD_QUERY, 31'd0, 8'd1);
      send_request(CMD_QUERY, 31'd0, 8'd3);
      send_request(CMD_QUERY, 31'd0, 8'hFF);
      send_request(CMD_RELEASE, 31'd0, 8'd1);
      send_request(CMD_RELEASE, 31'd0, 8'd1);
      send_request(CMD_QUERY, 31'd0, 8'd1);
      send_request(CMD_RESERVE, 31'h5555_5555, 8'd0);
      send_request(CMD_UNUSED, 31'h7FFF_FFFF, 8'hFF);
      send_request(CMD_RELEASE, 31'd0, 8'd0);

      // Full table: top slot in range
      write_room(9'd256);
      send_request(CMD_QUERY, 31'd0, 8'hFF);
      send_request(CMD_RELEASE, 31'd0, 8'hFF);
      send_request(CMD_RESERVE, 31'h1234_5678, 8'd0);

      // Random phases; the first runs without idling
      write_room(9'd256);
      steady <= 1'b1;
      run_random(50, 0);
      write_room(9'd1);
      steady <= 1'b0;
      run_random(40, 0);
      write_room(9'd2);
      run_random(40, 0);

      // Oversized room, filled past full while the result side holds off
      write_room(9'd511);
      pressure_armed <= 1'b1;
      run_random(340, 300);

      write_room(9'd0);
      run_random(30, 0);
      write_room(9'd40);
      run_random(60, 30);
      write_room(9'd130);
      run_random(100, 0);
      req_tvalid <= 1'b0;

      // Drain and let any stray result show up
      while (sb.pending() != 0) @(posedge clock);
      repeat (CHAIN_CYCLES + 8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[first_free_slot_allocator] OK");
      end else begin
         $display("[first_free_slot_allocator] ERROR");
      end
      $finish;
   end

endmodule
